// ----- rtl/core/fragc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the frame RMS automatic gain control block.
// Holds register indexes, reset values and level limits; depends on nothing.
package fragc_pkg;

  localparam int MAX_FRAME_DEF = 1024;

  localparam int LEVEL_W = 23;
  localparam int GAIN_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 23'h7FFFFF;
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LEN   = 3'd0,
    REG_SILENCE     = 3'd1,
    REG_TARGET      = 3'd2,
    REG_ADJUST      = 3'd3,
    REG_SMOOTH_W    = 3'd4,
    REG_QUIET_LIMIT = 3'd5,
    REG_DECAY       = 3'd6,
    REG_GAIN_FLOOR  = 3'd7
  } cfg_idx_t;

  localparam logic [10:0]        RST_FRAME_LEN   = 11'd256;
  localparam logic [LEVEL_W-1:0] RST_SILENCE     = 23'd512000;
  localparam logic [LEVEL_W-1:0] RST_TARGET      = 23'd1792000;
  localparam logic [15:0]        RST_ADJUST      = 16'd3277;
  localparam logic [15:0]        RST_SMOOTH_W    = 16'd6554;
  localparam logic [7:0]         RST_QUIET_LIMIT = 8'd60;
  localparam logic [15:0]        RST_DECAY       = 16'd64225;
  localparam logic [GAIN_W-1:0]  RST_GAIN_FLOOR  = 24'd655360;
  localparam logic [GAIN_W-1:0]  RST_GAIN        = 24'd655360;

endpackage

// ----- rtl/core/frame_rms_agc.sv -----
`timescale 1ns / 1ps
// Frame RMS automatic gain control: top level with its sequencer and shared units.
// Depends on fragc_pkg.
//
//   Channel  Ports                                   Direction  Transfer when
//   -------  --------------------------------------  ---------  --------------------
//   input    in_valid, in_ready, in_audio_in         in         in_valid & in_ready
//   result   out_valid, out_ready, out_audio_out,    out        out_valid & out_ready
//            out_frame_done, out_frame_level,
//            out_smoothed_level, out_gain_now
//   config   cfg_valid, cfg_ready, cfg_index,        in         cfg_valid & cfg_ready
//            cfg_data
//
// A sample that does not close a frame passes through S_MAUD, S_MSQ and S_ACC before its
// result is loaded into the output register in S_OUT. A sample that closes a frame passes
// through the 64-step shift-subtract divider and the 32 steps of the square root and, when the
// smoothed level is above silence, the divider again, with products on the shared 33x25 multiplier.
// The input is ready only while the sequencer is idle; a result waiting in the output
// register does not block the next transfer, but the sequencer holds before loading the
// next result until the previous one is taken. Configuration writes are accepted only
// while the sequencer is idle. Reset is synchronous and active low; it
// restores the configuration registers and all gain state to their defaults.
module frame_rms_agc
  import fragc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_audio_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_audio_out,
  output logic                  out_frame_done,
  output logic [LEVEL_W-1:0]    out_frame_level,
  output logic [LEVEL_W-1:0]    out_smoothed_level,
  output logic [GAIN_W-1:0]     out_gain_now,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Sample counter holds values up to the largest frame length.
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME);

  typedef enum logic [4:0] {
    S_IDLE, S_MAUD, S_MSQ, S_ACC, S_DIV, S_SQRT, S_SM1, S_SM2, S_SM3,
    S_DECIDE, S_T1, S_GA, S_GH, S_GL, S_GN, S_GSUM, S_DCY, S_DCY2, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [10:0]        frame_len_r;
  logic [LEVEL_W-1:0] silence_r;
  logic [LEVEL_W-1:0] target_r;
  logic [15:0]        adjust_r;
  logic [15:0]        smooth_w_r;
  logic [7:0]         quiet_limit_r;
  logic [15:0]        decay_r;
  logic [GAIN_W-1:0]  floor_r;

  // Gain state.
  logic [40:0]        energy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEVEL_W-1:0] ls_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [7:0]         quiet_r;

  // Working registers.
  logic signed [31:0] x_r;
  logic signed [31:0] aud_r;
  logic               done_r;
  logic signed [57:0] mul_p_r;
  logic [40:0]        acc_r;
  logic [19:0]        ga_lo_r;
  logic [42:0]        hi_r;
  logic [63:0]        num_r;
  logic [LEVEL_W-1:0] rem_r;
  logic [LEVEL_W-1:0] div_r;
  logic               div_sel_r;
  logic [5:0]         it_r;
  logic [31:0]        root_r;
  logic [33:0]        srem_r;

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] out_audio_r;
  logic               out_done_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_smooth_r;
  logic [GAIN_W-1:0]  out_gain_r;

  logic in_xfer;
  logic cfg_xfer;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Shared multiplier operand selection.
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [15:0] v_s;
  logic [23:0]        neg_adj;
  logic [16:0]        w_inv;
  logic [16:0]        a_inv;
  logic [LEVEL_W-1:0] lvl_c;

  // Sixteen-bit reduced sample: floor by 2^8, then truncate toward zero by 2^8.
  assign neg_adj = x_r[31:8] + 24'd255;
  assign v_s     = x_r[31] ? $signed(neg_adj[23:8]) : $signed(x_r[31:16]);
  assign w_inv   = 17'h10000 - {1'b0, smooth_w_r};
  assign a_inv   = 17'h10000 - {1'b0, adjust_r};
  assign lvl_c   = (root_r > 32'(LEVEL_MAX)) ? LEVEL_MAX : root_r[LEVEL_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MAUD: begin
        mul_a = 33'(x_r);
        mul_b = 25'(gain_r);
      end
      S_MSQ: begin
        mul_a = 33'(v_s);
        mul_b = 25'(v_s);
      end
      S_SM1: begin
        mul_a = 33'(ls_r);
        mul_b = 25'(w_inv);
      end
      S_SM2: begin
        mul_a = 33'(lvl_c);
        mul_b = 25'(smooth_w_r);
      end
      S_T1: begin
        mul_a = 33'(gain_r);
        mul_b = 25'(a_inv);
      end
      S_GA: begin
        mul_a = 33'(gain_r);
        mul_b = 25'(adjust_r);
      end
      S_GH: begin
        mul_a = 33'(mul_p_r[39:20]);
        mul_b = 25'(target_r);
      end
      S_GL: begin
        mul_a = 33'(ga_lo_r);
        mul_b = 25'(target_r);
      end
      S_DCY: begin
        mul_a = 33'(gain_r);
        mul_b = 25'(decay_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Scaled sample: truncate toward zero, then saturate to the 32-bit range.
  logic signed [57:0] p_adj;
  logic signed [41:0] p_q;
  logic signed [31:0] aud_nxt;
  assign p_adj = mul_p_r + (mul_p_r[57] ? 58'sd65535 : 58'sd0);
  assign p_q   = p_adj[57:16];
  always_comb begin
    if (p_q > 42'sd2147483647) begin
      aud_nxt = 32'sh7FFFFFFF;
    end else if (p_q < -42'sd2147483648) begin
      aud_nxt = 32'sh80000000;
    end else begin
      aud_nxt = p_q[31:0];
    end
  end

  // Energy accumulation with saturation, and frame length clamp.
  logic [41:0]      e_sum;
  logic [40:0]      energy_nxt;
  logic [CMP_W-1:0] fl_ext;
  logic [CMP_W-1:0] len_c;
  logic [CNT_W-1:0] cnt_inc;
  logic             close_c;
  assign e_sum      = {1'b0, energy_r} + 42'(mul_p_r[30:0]);
  assign energy_nxt = e_sum[41] ? {41{1'b1}} : e_sum[40:0];
  assign fl_ext     = CMP_W'(frame_len_r);
  assign len_c      = (fl_ext == '0) ? CMP_W'(1) : ((fl_ext > MAX_LEN) ? MAX_LEN : fl_ext);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign close_c    = (CMP_W'(cnt_inc) >= len_c);

  // One restoring divider step.
  logic [LEVEL_W:0] d_sh;
  logic             d_ge;
  logic [LEVEL_W:0] d_diff;
  assign d_sh   = {rem_r, num_r[63]};
  assign d_ge   = (d_sh >= {1'b0, div_r});
  assign d_diff = d_sh - {1'b0, div_r};

  // One square root step, two radicand bits per step.
  logic [35:0] s_sh;
  logic [35:0] s_trial;
  logic        s_ge;
  logic [35:0] s_diff;
  assign s_sh    = {srem_r, num_r[63:62]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign s_ge    = (s_sh >= s_trial);
  assign s_diff  = s_sh - s_trial;

  // Smoothing and gain update arithmetic.
  logic [41:0]       sm_sum;
  logic [64:0]       g_sum;
  logic [48:0]       g_sh;
  logic [GAIN_W-1:0] g_adapt;
  logic [GAIN_W-1:0] g_decay;
  logic [GAIN_W-1:0] g_cand;
  logic [GAIN_W-1:0] gain_nxt;
  logic [7:0]        quiet_nxt;
  assign sm_sum    = {1'b0, acc_r} + {1'b0, mul_p_r[40:0]};
  assign g_sum     = 65'(acc_r) + 65'(num_r);
  assign g_sh      = g_sum[64:16];
  assign g_adapt   = (g_sh > 49'(GAIN_MAX)) ? GAIN_MAX : g_sh[GAIN_W-1:0];
  assign g_decay   = mul_p_r[39:16];
  assign quiet_nxt = (quiet_r == 8'hFF) ? quiet_r : quiet_r + 8'd1;

  always_comb begin
    case (state_r)
      S_GSUM:  g_cand = g_adapt;
      S_DCY2:  g_cand = g_decay;
      default: g_cand = gain_r;
    endcase
  end
  assign gain_nxt = (g_cand < floor_r) ? floor_r : g_cand;

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      frame_len_r   <= RST_FRAME_LEN;
      silence_r     <= RST_SILENCE;
      target_r      <= RST_TARGET;
      adjust_r      <= RST_ADJUST;
      smooth_w_r    <= RST_SMOOTH_W;
      quiet_limit_r <= RST_QUIET_LIMIT;
      decay_r       <= RST_DECAY;
      floor_r       <= RST_GAIN_FLOOR;
      energy_r      <= '0;
      cnt_r         <= '0;
      ls_r          <= '0;
      gain_r        <= RST_GAIN;
      quiet_r       <= '0;
    end else begin
      if (cfg_xfer) begin
        case (cfg_idx_t'(cfg_index))
          REG_FRAME_LEN:   frame_len_r   <= cfg_data[10:0];
          REG_SILENCE:     silence_r     <= cfg_data[LEVEL_W-1:0];
          REG_TARGET:      target_r      <= cfg_data[LEVEL_W-1:0];
          REG_ADJUST:      adjust_r      <= cfg_data[15:0];
          REG_SMOOTH_W:    smooth_w_r    <= cfg_data[15:0];
          REG_QUIET_LIMIT: quiet_limit_r <= cfg_data[7:0];
          REG_DECAY:       decay_r       <= cfg_data[15:0];
          REG_GAIN_FLOOR:  floor_r       <= cfg_data[GAIN_W-1:0];
          default:         frame_len_r   <= frame_len_r;
        endcase
      end

      // The load in S_OUT covers the case where the waiting result is taken.
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            x_r     <= in_audio_in;
            state_r <= S_MAUD;
          end
        end
        S_MAUD: begin
          state_r <= S_MSQ;
        end
        S_MSQ: begin
          aud_r   <= aud_nxt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          done_r <= close_c;
          if (close_c) begin
            energy_r  <= '0;
            cnt_r     <= '0;
            num_r     <= {7'd0, energy_nxt, 16'd0};
            rem_r     <= '0;
            div_r     <= LEVEL_W'(len_c);
            div_sel_r <= 1'b0;
            it_r      <= '0;
            state_r   <= S_DIV;
          end else begin
            energy_r <= energy_nxt;
            cnt_r    <= cnt_inc;
            state_r  <= S_OUT;
          end
        end
        S_DIV: begin
          rem_r <= d_ge ? d_diff[LEVEL_W-1:0] : d_sh[LEVEL_W-1:0];
          num_r <= {num_r[62:0], d_ge};
          // The step counter wraps back to zero after the last step.
          it_r  <= it_r + 6'd1;
          if (it_r == 6'd63) begin
            if (!div_sel_r) begin
              root_r <= '0;
              srem_r <= '0;
            end
            state_r <= div_sel_r ? S_GSUM : S_SQRT;
          end
        end
        S_SQRT: begin
          srem_r <= s_ge ? s_diff[33:0] : s_sh[33:0];
          root_r <= {root_r[30:0], s_ge};
          num_r  <= {num_r[61:0], 2'b00};
          it_r   <= it_r + 6'd1;
          if (it_r == 6'd31) begin
            state_r <= S_SM1;
          end
        end
        S_SM1: begin
          state_r <= S_SM2;
        end
        S_SM2: begin
          acc_r   <= mul_p_r[40:0];
          state_r <= S_SM3;
        end
        S_SM3: begin
          ls_r    <= sm_sum[38:16];
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (ls_r > silence_r) begin
            quiet_r <= '0;
            state_r <= S_T1;
          end else begin
            quiet_r <= quiet_nxt;
            if (quiet_nxt > quiet_limit_r) begin
              state_r <= S_DCY;
            end else begin
              gain_r  <= gain_nxt;
              state_r <= S_OUT;
            end
          end
        end
        S_T1: begin
          state_r <= S_GA;
        end
        S_GA: begin
          acc_r   <= mul_p_r[40:0];
          state_r <= S_GH;
        end
        S_GH: begin
          ga_lo_r <= mul_p_r[19:0];
          state_r <= S_GL;
        end
        S_GL: begin
          hi_r    <= mul_p_r[42:0];
          state_r <= S_GN;
        end
        S_GN: begin
          // Numerator gain * step * target, rebuilt from two partial products.
          num_r     <= {hi_r[43-1:0], 20'd0} + 64'(mul_p_r[42:0]);
          rem_r     <= '0;
          div_r     <= ls_r;
          div_sel_r <= 1'b1;
          it_r      <= '0;
          state_r   <= S_DIV;
        end
        S_GSUM: begin
          gain_r  <= gain_nxt;
          state_r <= S_OUT;
        end
        S_DCY: begin
          state_r <= S_DCY2;
        end
        S_DCY2: begin
          gain_r  <= gain_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_audio_r  <= aud_r;
            out_done_r   <= done_r;
            out_level_r  <= done_r ? lvl_c : '0;
            out_smooth_r <= ls_r;
            out_gain_r   <= gain_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_audio_out      = out_audio_r;
  assign out_frame_done     = out_done_r;
  assign out_frame_level    = out_level_r;
  assign out_smoothed_level = out_smooth_r;
  assign out_gain_now       = out_gain_r;

  // The divider remainder always stays below its divisor.
  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // The square root remainder never exceeds twice the partial root.
  a_sqrt_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (35'(srem_r) <= {3'b000, root_r} + {3'b000, root_r}))
    else $error("square root remainder too large");

  // A frame-closing result carries a gain at or above the floor.
  a_gain_floor : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_gain_r >= floor_r))
    else $error("gain below floor after frame close");

  // Results that do not close a frame report a zero frame level.
  a_level_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> (out_level_r == '0))
    else $error("frame level set without frame close");

  // The sample counter never passes the largest frame length.
  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(cnt_r) <= MAX_LEN))
    else $error("sample counter out of range");

endmodule
